// ===== sv/dq_pkg.sv =====
// shared types, codes and widths for the double-ended queue
package dq_pkg;

    localparam int VALUE_W       = 32;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    // operation codes carried on the input channel
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_PUSH_REAR  = 3'd3,
        CMD_POP_REAR   = 3'd4,
        CMD_MARK       = 3'd5,
        CMD_ROTATE     = 3'd6
    } t_cell_cmd;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      tag;
    } t_cell;

endpackage

// ===== sv/dq_in_if.sv =====
// input channel: operation code and value to push
interface dq_in_if import dq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output func, output item_value, input ready);
    modport sink   (input valid, input func, input item_value, output ready);
endinterface

// ===== sv/dq_out_if.sv =====
// output channel: popped or dumped value with status and last flag
interface dq_out_if import dq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       status;
    logic                      last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values built as a chain of cells.
// Input channel i_in carries func (push front, pop front, push rear, pop rear,
// dump) and item_value; output channel o_out returns out_value, status, last.
// Every push and pop gives one result, registered, in the cycle after the input
// transfer; a new input is taken in every cycle while the output register is
// free or being drained, so push and pop run at one item per cycle.
// A dump first tags the rear entry and then emits one entry per cycle while the
// output is free, front to rear, by rotating the whole chain one cell toward the
// front; after count rotations the chain is back in place. No input is taken
// until the dump has emitted its tagged rear entry.
// Full and empty come straight from the valid bits of the last and first cells.
// Reset (synchronous, active low) empties the queue at once and drops any
// pending result. When the receiver stalls the output register holds its
// result, the dump pauses and the input side is held off.
// Unused operation codes are taken and give no result.
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dq_in_if.sink     i_in,
    dq_out_if.source  o_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic [STATUS_W-1:0]       r_out_status, n_out_status;
    logic                      r_out_last, n_out_last;
    logic                      r_out_valid, n_out_valid;

    t_cell      w_cell  [DEPTH];
    t_cell      w_left  [DEPTH];
    t_cell      w_right [DEPTH];
    logic [DEPTH-1:0] w_rear;
    t_cell_cmd  w_cmd;

    logic                      w_out_free;
    logic                      w_accept;
    logic                      w_empty;
    logic                      w_full;
    logic signed [VALUE_W-1:0] w_rear_value;

    // chain of cells with neighbor wiring
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = '{value: i_in.item_value, valid: 1'b1, tag: 1'b0};
        end else begin : g_mid_left
            assign w_left[gi] = w_cell[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right[gi] = '{value: '0, valid: 1'b0, tag: 1'b0};
        end else begin : g_mid_right
            assign w_right[gi] = w_cell[gi+1];
        end

        dq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left       (w_left[gi]),
            .i_right      (w_right[gi]),
            .i_head       (w_cell[0]),
            .i_push_value (i_in.item_value),
            .o_cell       (w_cell[gi]),
            .o_rear       (w_rear[gi])
        );
    end

    // rear value select, one-hot over the cells
    always_comb begin
        w_rear_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear_value = w_rear_value | (w_cell[k].value & {VALUE_W{w_rear[k]}});
        end
    end

    // handshake and queue status
    assign w_empty    = !w_cell[0].valid;
    assign w_full     = w_cell[DEPTH-1].valid;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    // operation decode and result formation
    always_comb begin
        n_state      = r_state;
        w_cmd        = CMD_HOLD;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !o_out.ready;

        if (w_accept) begin
            case (i_in.func)
                FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    if (w_full) begin
                        n_out_status = STATUS_FULL;
                    end else begin
                        n_out_status = STATUS_OK;
                        w_cmd = (i_in.func == FUNC_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                : CMD_PUSH_REAR;
                    end
                end
                FUNC_POP_FRONT, FUNC_POP_REAR: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (w_empty) begin
                        n_out_status = STATUS_EMPTY;
                        n_out_value  = '0;
                    end else if (i_in.func == FUNC_POP_FRONT) begin
                        n_out_status = STATUS_OK;
                        n_out_value  = w_cell[0].value;
                        w_cmd        = CMD_POP_FRONT;
                    end else begin
                        n_out_status = STATUS_OK;
                        n_out_value  = w_rear_value;
                        w_cmd        = CMD_POP_REAR;
                    end
                end
                FUNC_DUMP: begin
                    if (w_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_EMPTY;
                        n_out_value  = '0;
                        n_out_last   = 1'b1;
                    end else begin
                        w_cmd   = CMD_MARK;
                        n_state = ST_DUMP;
                    end
                end
                default: begin
                    w_cmd = CMD_HOLD;
                end
            endcase
        end else if (r_state == ST_DUMP && w_out_free) begin
            // emit the front entry and rotate the chain
            n_out_valid  = 1'b1;
            n_out_status = STATUS_OK;
            n_out_value  = w_cell[0].value;
            n_out_last   = w_cell[0].tag;
            w_cmd        = CMD_ROTATE;
            if (w_cell[0].tag) begin
                n_state = ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.status    = r_out_status;
    assign o_out.last      = r_out_last;

endmodule

// ===== sv/dq_cell.sv =====
// one storage cell of the queue chain, front cell at position zero
module dq_cell import dq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_cmd                 i_cmd,
    input  t_cell                     i_left,
    input  t_cell                     i_right,
    input  t_cell                     i_head,
    input  logic signed [VALUE_W-1:0] i_push_value,
    output t_cell                     o_cell,
    output logic                      o_rear
);

    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_valid, n_valid;
    logic                      r_tag, n_tag;
    logic                      w_is_rear;

    // this cell holds the rear entry when its right neighbor is empty
    assign w_is_rear = r_valid && !i_right.valid;

    // next contents per broadcast command
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        n_tag   = r_tag;
        case (i_cmd)
            CMD_PUSH_FRONT: begin
                n_value = i_left.value;
                n_valid = i_left.valid;
                n_tag   = 1'b0;
            end
            CMD_POP_FRONT: begin
                n_value = i_right.value;
                n_valid = i_right.valid;
                n_tag   = 1'b0;
            end
            CMD_PUSH_REAR: begin
                if (!r_valid && i_left.valid) begin
                    n_value = i_push_value;
                    n_valid = 1'b1;
                end
            end
            CMD_POP_REAR: begin
                if (w_is_rear) begin
                    n_valid = 1'b0;
                end
            end
            CMD_MARK: begin
                n_tag = w_is_rear;
            end
            CMD_ROTATE: begin
                // shift toward the front, the old front wraps into the rear cell
                if (i_right.valid) begin
                    n_value = i_right.value;
                    n_tag   = i_right.tag;
                end else if (r_valid) begin
                    n_value = i_head.value;
                    n_tag   = 1'b0;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tag   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tag   <= n_tag;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_cell = '{value: r_value, valid: r_valid, tag: r_tag};
    assign o_rear = w_is_rear;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the double-ended queue: predictor, scoreboard and stimulus
module testbench import dq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES  = DEPTH + 4;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // codes the block takes and ignores
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_deque_result;

    // ring-store predictor plus the queue of results still owed by the block
    class deque_scoreboard;
        logic signed [VALUE_W-1:0] ring [DEPTH];
        int unsigned               head;
        int unsigned               fill;
        t_deque_result             owed_q[$];
        int                        failures;
        int                        n_push, n_full, n_pop, n_empty, n_dump, n_spare, n_results;

        function new();
            head = 0;
            fill = 0;
            failures = 0;
            n_push = 0; n_full = 0; n_pop = 0; n_empty = 0;
            n_dump = 0; n_spare = 0; n_results = 0;
        endfunction

        function void owe(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                          logic last);
            t_deque_result r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            owed_q.push_back(r);
        endfunction

        // apply one accepted input transfer and queue the results it causes
        function void note_transfer(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value);
            int unsigned pos;
            case (func)
                FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                    n_push++;
                    if (fill == DEPTH) begin
                        n_full++;
                        owe('0, STATUS_FULL, 1'b1);
                    end else begin
                        if (func == FUNC_PUSH_FRONT) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            ring[head] = value;
                        end else begin
                            ring[(head + fill) % DEPTH] = value;
                        end
                        fill++;
                        owe('0, STATUS_OK, 1'b1);
                    end
                end
                FUNC_POP_FRONT, FUNC_POP_REAR: begin
                    n_pop++;
                    if (fill == 0) begin
                        n_empty++;
                        owe('0, STATUS_EMPTY, 1'b1);
                    end else begin
                        if (func == FUNC_POP_FRONT) begin
                            pos  = head;
                            head = (head + 1) % DEPTH;
                        end else begin
                            pos = (head + fill - 1) % DEPTH;
                        end
                        fill--;
                        owe(ring[pos], STATUS_OK, 1'b1);
                    end
                end
                FUNC_DUMP: begin
                    n_dump++;
                    if (fill == 0) begin
                        n_empty++;
                        owe('0, STATUS_EMPTY, 1'b1);
                    end else begin
                        for (int k = 0; k < fill; k++)
                            owe(ring[(head + k) % DEPTH], STATUS_OK, (k + 1 == fill));
                    end
                end
                default: begin
                    n_spare++;
                end
            endcase
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("error: %s", msg);
        endfunction

        // compare one output transfer with the oldest owed result
        function void check_result(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic last);
            t_deque_result exp;
            n_results++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result value %0d status %0d last %0d",
                                 value, status, last));
                return;
            end
            exp = owed_q.pop_front();
            if (value !== exp.value || status !== exp.status || last !== exp.last)
                report($sformatf({"result %0d: expected value %0d status %0d last %0d, ",
                                  "got value %0d status %0d last %0d"},
                                 n_results, exp.value, exp.status, exp.last,
                                 value, status, last));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_in_if  in_ch ();
    dq_out_if out_ch ();

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    deque_scoreboard sb = new();

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int cycle_count  = 0;

    // clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_transfer(in_ch.func, in_ch.item_value);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_value, out_ch.status, out_ch.last);
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(rx_idle_on && $urandom_range(99) < 8);
        end
    end

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // offer one item and hold it until the transfer; returns at a falling edge
    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic signed [VALUE_W-1:0] value);
        while (tx_idle_on && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.item_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every owed result, then let the block settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct, input int dump_pct);
        int                roll;
        logic [FUNC_W-1:0] func;
        roll = $urandom_range(99);
        if (roll < push_pct)
            func = $urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            func = $urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
        else if (roll < push_pct + pop_pct + dump_pct)
            func = FUNC_DUMP;
        else
            func = FUNC_W'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
        send_item(func, random_value());
    endtask

    task automatic run_phase(input int count, input int push_pct, input int pop_pct,
                             input int dump_pct);
        repeat (count) send_random(push_pct, pop_pct, dump_pct);
        wait_drained();
    endtask

    // main sequence
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_PUSH_FRONT;
        in_ch.item_value = '0;
        out_ch.ready     = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue, extreme values, wrap at the front, unused codes
        send_item(FUNC_POP_FRONT, VALUE_MAX);
        send_item(FUNC_POP_REAR, VALUE_MIN);
        send_item(FUNC_DUMP, '0);
        send_item(FUNC_PUSH_FRONT, VALUE_MAX);
        send_item(FUNC_PUSH_REAR, VALUE_MIN);
        send_item(FUNC_PUSH_FRONT, -1);
        send_item(FUNC_PUSH_REAR, '0);
        send_item(FUNC_DUMP, -1);
        send_item(FUNC_SPARE_FIRST, VALUE_MAX);
        send_item(FUNC_SPARE_MID, '0);
        send_item(FUNC_SPARE_LAST, -1);
        send_item(FUNC_POP_FRONT, '0);
        send_item(FUNC_POP_REAR, '0);
        send_item(FUNC_POP_FRONT, '0);
        send_item(FUNC_POP_REAR, '0);
        send_item(FUNC_POP_REAR, '0);
        send_item(FUNC_PUSH_REAR, 32'sh5555_5555);
        send_item(FUNC_PUSH_REAR, 32'shAAAA_AAAA);
        send_item(FUNC_DUMP, '0);
        send_item(FUNC_POP_FRONT, '0);
        send_item(FUNC_POP_FRONT, '0);
        wait_drained();

        // receiver holds off and stalls the pushes, which then fill the queue and are rejected when full
        rx_hold_req = 1'b1;
        repeat (DEPTH + 6)
            send_item($urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT, random_value());
        send_item(FUNC_DUMP, '0);
        repeat (DEPTH + 2)
            send_item($urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT, '0);
        send_item(FUNC_DUMP, '0);
        wait_drained();

        // random: filling, draining, balanced without stalls, filling again
        run_phase(70, 60, 30, 7);
        run_phase(70, 30, 60, 7);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(80, 45, 45, 8);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_phase(70, 65, 25, 8);

        if (sb.owed_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));

        $display("covered %0d pushes (%0d rejected full), %0d pops, %0d dumps, %0d unused codes",
                 sb.n_push, sb.n_full, sb.n_pop, sb.n_dump, sb.n_spare);
        $display("checked %0d results, %0d on an empty queue, %0d failures",
                 sb.n_results, sb.n_empty, sb.failures);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dq_pkg.sv
sv/dq_in_if.sv
sv/dq_out_if.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
test/testbench.sv
